// ===== design/adll_pkg.sv =====
// Shared types and codes for the array-based doubly linked list core.
`timescale 1ns / 1ps

package adll_pkg;

    // Command codes; the two remaining 3-bit codes are ignored by the core.
    typedef enum logic [2:0] {
        KIND_APPEND     = 3'd0,
        KIND_PREPEND    = 3'd1,
        KIND_INSERT     = 3'd2,
        KIND_DROP_BACK  = 3'd3,
        KIND_DROP_FRONT = 3'd4,
        KIND_ERASE      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    localparam int KIND_W     = 3;
    localparam int POSITION_W = 11;
    localparam int LENGTH_W   = 11;
    localparam int VALUE_W    = 32;

endpackage

// ===== design/adll_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module adll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/array_doubly_linked_list_core.sv =====
// Doubly linked list core: node links and data in RAM, sentinel links in registers.
// One command at a time; the next input transfer can come in the cycle after the result is
// registered. Insert and erase reach position p by walking one link per cycle from the head.
// Synchronous active-low reset empties the list at once; node RAM is not cleared.
`timescale 1ns / 1ps

module array_doubly_linked_list_core #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [adll_pkg::KIND_W-1:0]         i_kind,
    input  logic [adll_pkg::POSITION_W-1:0]     i_position,
    input  logic signed [adll_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic [adll_pkg::LENGTH_W-1:0]       o_length,
    output logic signed [adll_pkg::VALUE_W-1:0] o_removed_value
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int SW = $clog2(NODE_COUNT + 2);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int PW = adll_pkg::POSITION_W;
    localparam int MW = (CW > PW) ? CW : PW;
    localparam int VW = adll_pkg::VALUE_W;
    localparam int LW = adll_pkg::LENGTH_W;

    localparam logic [SW-1:0] HEAD_SLOT = SW'(NODE_COUNT);
    localparam logic [SW-1:0] TAIL_SLOT = SW'(NODE_COUNT + 1);
    localparam logic [CW-1:0] POOL_SIZE = CW'(NODE_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_WALK,
        S_LINK_RD,
        S_LINK_W1,
        S_LINK_W2,
        S_UNLINK_RD,
        S_UNLINK_WR,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [2:0]      r_kind;
    logic [PW-1:0]   r_pos;
    logic [VW-1:0]   r_value;
    logic [PW-1:0]   r_rem;
    logic [SW-1:0]   r_target;
    logic [SW-1:0]   r_before;
    logic [SW-1:0]   r_head_next;
    logic [SW-1:0]   r_tail_prev;
    logic [CW-1:0]   r_alloc;
    logic [CW-1:0]   r_count;
    logic [1:0]      r_res_status;
    logic [VW-1:0]   r_res_removed;
    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [LW-1:0]   r_out_length;
    logic [VW-1:0]   r_out_removed;

    logic [SW-1:0]   w_next_rdata;
    logic [SW-1:0]   w_prev_rdata;
    logic [VW-1:0]   w_value_rdata;
    logic [IW-1:0]   w_next_raddr;
    logic            w_next_we;
    logic [IW-1:0]   w_next_waddr;
    logic [SW-1:0]   w_next_wdata;
    logic            w_prev_we;
    logic [IW-1:0]   w_prev_waddr;
    logic [SW-1:0]   w_prev_wdata;
    logic            w_value_we;
    logic [SW-1:0]   w_before;
    logic [SW-1:0]   w_new_slot;
    logic [MW-1:0]   w_pos_ext;
    logic [MW-1:0]   w_cnt_ext;
    logic            w_is_erase;
    logic            w_out_free;
    logic            w_load_out;
    logic [CW+LW-1:0] w_len_ext;

    assign o_ready    = (r_state == S_IDLE);
    assign w_pos_ext  = MW'(r_pos);
    assign w_cnt_ext  = MW'(r_count);
    assign w_new_slot = SW'(r_alloc);
    assign w_is_erase = (r_kind == adll_pkg::KIND_ERASE);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_load_out = (r_state == S_DONE) && w_out_free;
    assign w_len_ext  = {{LW{1'b0}}, r_count};
    // Slot in front of the insertion point; the tail's prev link lives in a register.
    assign w_before   = (r_target == TAIL_SLOT) ? r_tail_prev : w_prev_rdata;

    always_comb begin
        w_next_raddr = r_target[IW-1:0];
        w_next_we    = 1'b0;
        w_next_waddr = r_alloc[IW-1:0];
        w_next_wdata = r_target;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_alloc[IW-1:0];
        w_prev_wdata = w_before;
        w_value_we   = 1'b0;
        unique case (r_state)
            S_CMD: begin
                w_next_raddr = r_head_next[IW-1:0];
            end
            S_WALK: begin
                // Chase the link straight from the RAM output, one hop per cycle.
                w_next_raddr = w_next_rdata[IW-1:0];
            end
            S_LINK_W1: begin
                w_next_we  = 1'b1;
                w_prev_we  = 1'b1;
                w_value_we = 1'b1;
            end
            S_LINK_W2: begin
                w_next_we    = (r_before != HEAD_SLOT);
                w_next_waddr = r_before[IW-1:0];
                w_next_wdata = w_new_slot;
                w_prev_we    = (r_target != TAIL_SLOT);
                w_prev_waddr = r_target[IW-1:0];
                w_prev_wdata = w_new_slot;
            end
            S_UNLINK_WR: begin
                w_next_we    = (w_prev_rdata != HEAD_SLOT);
                w_next_waddr = w_prev_rdata[IW-1:0];
                w_next_wdata = w_next_rdata;
                w_prev_we    = (w_next_rdata != TAIL_SLOT);
                w_prev_waddr = w_next_rdata[IW-1:0];
                w_prev_wdata = w_prev_rdata;
            end
            default: begin
            end
        endcase
    end

    adll_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_next_raddr),
        .o_rdata (w_next_rdata)
    );

    adll_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_waddr),
        .i_wdata (w_prev_wdata),
        .i_raddr (r_target[IW-1:0]),
        .o_rdata (w_prev_rdata)
    );

    adll_ram #(.WIDTH(VW), .DEPTH(NODE_COUNT)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_value_we),
        .i_waddr (r_alloc[IW-1:0]),
        .i_wdata (r_value),
        .i_raddr (r_target[IW-1:0]),
        .o_rdata (w_value_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_alloc     <= '0;
            r_count     <= '0;
            r_head_next <= TAIL_SLOT;
            r_tail_prev <= HEAD_SLOT;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_pos   <= i_position;
                        r_value <= i_value;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_res_status  <= adll_pkg::ST_OK;
                    r_res_removed <= '0;
                    r_rem         <= r_pos;
                    case (r_kind) inside
                        adll_pkg::KIND_APPEND, adll_pkg::KIND_PREPEND,
                        adll_pkg::KIND_INSERT: begin
                            if (r_alloc == POOL_SIZE) begin
                                r_res_status <= adll_pkg::ST_FULL;
                                r_state      <= S_DONE;
                            end else if (r_kind == adll_pkg::KIND_APPEND) begin
                                r_target <= TAIL_SLOT;
                                r_state  <= S_LINK_RD;
                            end else if (r_kind == adll_pkg::KIND_PREPEND) begin
                                r_target <= r_head_next;
                                r_state  <= S_LINK_RD;
                            end else if (w_pos_ext > w_cnt_ext) begin
                                r_res_status <= adll_pkg::ST_RANGE;
                                r_state      <= S_DONE;
                            end else begin
                                r_target <= r_head_next;
                                r_state  <= (r_pos == '0) ? S_LINK_RD : S_WALK;
                            end
                        end
                        adll_pkg::KIND_DROP_BACK, adll_pkg::KIND_DROP_FRONT,
                        adll_pkg::KIND_ERASE: begin
                            if (r_count == '0) begin
                                r_res_status <= adll_pkg::ST_EMPTY;
                                r_state      <= S_DONE;
                            end else if (r_kind == adll_pkg::KIND_DROP_BACK) begin
                                r_target <= r_tail_prev;
                                r_state  <= S_UNLINK_RD;
                            end else if (r_kind == adll_pkg::KIND_DROP_FRONT) begin
                                r_target <= r_head_next;
                                r_state  <= S_UNLINK_RD;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                r_res_status <= adll_pkg::ST_RANGE;
                                r_state      <= S_DONE;
                            end else begin
                                r_target <= r_head_next;
                                r_state  <= (r_pos == '0) ? S_UNLINK_RD : S_WALK;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_WALK: begin
                    r_rem <= r_rem - 1'b1;
                    if (r_rem == PW'(1)) begin
                        r_target <= w_next_rdata;
                        r_state  <= w_is_erase ? S_UNLINK_RD : S_LINK_RD;
                    end
                end
                S_LINK_RD: begin
                    r_state <= S_LINK_W1;
                end
                S_LINK_W1: begin
                    r_before <= w_before;
                    r_state  <= S_LINK_W2;
                end
                S_LINK_W2: begin
                    if (r_before == HEAD_SLOT) begin
                        r_head_next <= w_new_slot;
                    end
                    if (r_target == TAIL_SLOT) begin
                        r_tail_prev <= w_new_slot;
                    end
                    r_alloc <= r_alloc + 1'b1;
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_UNLINK_RD: begin
                    r_state <= S_UNLINK_WR;
                end
                S_UNLINK_WR: begin
                    if (w_prev_rdata == HEAD_SLOT) begin
                        r_head_next <= w_next_rdata;
                    end
                    if (w_next_rdata == TAIL_SLOT) begin
                        r_tail_prev <= w_prev_rdata;
                    end
                    r_res_removed <= w_value_rdata;
                    r_count       <= r_count - 1'b1;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_out_status  <= r_res_status;
                        r_out_length  <= w_len_ext[LW-1:0];
                        r_out_removed <= r_res_removed;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_length        = r_out_length;
    assign o_removed_value = r_out_removed;

`ifndef ASSERT_OFF
    a_count_le_alloc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_alloc)
        else $error("list length exceeds allocated nodes");

    a_alloc_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= POOL_SIZE)
        else $error("allocator ran past the node pool");

    a_empty_links : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head_next == TAIL_SLOT))
        else $error("head link disagrees with list length");

    a_count_change : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |->
            ($past(r_state) == S_LINK_W2 || $past(r_state) == S_UNLINK_WR))
        else $error("list length changed outside a link update");

    a_result_loaded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (o_valid && r_state == S_IDLE))
        else $error("finished command did not reach the output register");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the array-based doubly linked list core.
`timescale 1ns / 1ps

module testbench;

    localparam int PW        = adll_pkg::POSITION_W;
    localparam int KW        = adll_pkg::KIND_W;
    localparam int LW        = adll_pkg::LENGTH_W;
    localparam int VW        = adll_pkg::VALUE_W;
    localparam int NODES     = 1024;
    localparam int SLOTS     = NODES + 2;
    localparam int RING      = 8;
    localparam logic [PW-1:0] HEAD_SLOT = PW'(NODES);
    localparam logic [PW-1:0] TAIL_SLOT = PW'(NODES + 1);

    // The two 3-bit command codes that the core leaves unused.
    localparam logic [KW-1:0] KIND_UNUSED_A = 3'd6;
    localparam logic [KW-1:0] KIND_UNUSED_B = 3'd7;

    // Command mixes for the random part.
    localparam int MIX_BALANCED = 0;
    localparam int MIX_FILL     = 1;
    localparam int MIX_SHRINK   = 2;

    typedef struct packed {
        adll_pkg::t_status    status;
        logic [LW-1:0]        length;
        logic signed [VW-1:0] removed;
    } t_list_result;

    class t_list_scoreboard;
        logic [PW-1:0]        next_of [SLOTS];
        logic [PW-1:0]        prev_of [SLOTS];
        logic signed [VW-1:0] data_of [NODES];
        logic [PW-1:0]        alloc_ptr;
        logic [LW-1:0]        count;
        t_list_result         expected_buf [RING];
        int                   wr_idx;
        int                   rd_idx;
        int                   errors;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                next_of[s] = '0;
                prev_of[s] = '0;
            end
            for (int s = 0; s < NODES; s++) begin
                data_of[s] = '0;
            end
            next_of[HEAD_SLOT] = TAIL_SLOT;
            prev_of[TAIL_SLOT] = HEAD_SLOT;
            alloc_ptr = '0;
            count = '0;
            wr_idx = 0;
            rd_idx = 0;
            errors = 0;
        endfunction

        // A link that points outside the slot range is treated as the tail.
        function logic [PW-1:0] clamp(logic [PW-1:0] s);
            return (s < SLOTS) ? s : TAIL_SLOT;
        endfunction

        function logic [PW-1:0] slot_at(logic [PW-1:0] pos);
            logic [PW-1:0] cur;
            cur = clamp(next_of[HEAD_SLOT]);
            for (int i = 0; i < pos; i++) begin
                cur = clamp(next_of[cur]);
            end
            return cur;
        endfunction

        function void link_in(logic [PW-1:0] after, logic signed [VW-1:0] val);
            logic [PW-1:0] n;
            logic [PW-1:0] prior;
            n = alloc_ptr;
            prior = clamp(prev_of[after]);
            data_of[n] = val;
            prev_of[n] = prior;
            next_of[prior] = n;
            next_of[n] = after;
            prev_of[after] = n;
            alloc_ptr++;
            count++;
        endfunction

        function logic signed [VW-1:0] unlink(logic [PW-1:0] t);
            logic [PW-1:0] prior;
            logic [PW-1:0] after;
            logic signed [VW-1:0] v;
            prior = clamp(prev_of[t]);
            after = clamp(next_of[t]);
            v = (t < NODES) ? data_of[t] : '0;
            next_of[prior] = after;
            prev_of[after] = prior;
            count--;
            return v;
        endfunction

        function void note_command(logic [KW-1:0] kind, logic [PW-1:0] pos,
                                   logic signed [VW-1:0] val);
            t_list_result res;
            res.status = adll_pkg::ST_OK;
            res.removed = '0;
            case (kind)
                adll_pkg::KIND_APPEND, adll_pkg::KIND_PREPEND, adll_pkg::KIND_INSERT: begin
                    // The pool check comes before the range check of an insert.
                    if (alloc_ptr >= NODES) begin
                        res.status = adll_pkg::ST_FULL;
                    end else if (kind == adll_pkg::KIND_APPEND) begin
                        link_in(TAIL_SLOT, val);
                    end else if (kind == adll_pkg::KIND_PREPEND) begin
                        link_in(clamp(next_of[HEAD_SLOT]), val);
                    end else if (pos > count) begin
                        res.status = adll_pkg::ST_RANGE;
                    end else begin
                        link_in(slot_at(pos), val);
                    end
                end
                adll_pkg::KIND_DROP_BACK, adll_pkg::KIND_DROP_FRONT,
                adll_pkg::KIND_ERASE: begin
                    if (count == 0) begin
                        res.status = adll_pkg::ST_EMPTY;
                    end else if (kind == adll_pkg::KIND_DROP_BACK) begin
                        res.removed = unlink(clamp(prev_of[TAIL_SLOT]));
                    end else if (kind == adll_pkg::KIND_DROP_FRONT) begin
                        res.removed = unlink(clamp(next_of[HEAD_SLOT]));
                    end else if (pos >= count) begin
                        res.status = adll_pkg::ST_RANGE;
                    end else begin
                        res.removed = unlink(slot_at(pos));
                    end
                end
                default: begin
                end
            endcase
            res.length = count;
            if (wr_idx - rd_idx >= RING) begin
                $error("too many commands outstanding");
                errors++;
            end
            expected_buf[wr_idx % RING] = res;
            wr_idx++;
        endfunction

        function void check_result(logic [1:0] status, logic [LW-1:0] length,
                                   logic signed [VW-1:0] removed);
            t_list_result want;
            if (wr_idx == rd_idx) begin
                $error("result transfer with no command outstanding");
                errors++;
                return;
            end
            want = expected_buf[rd_idx % RING];
            rd_idx++;
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (length !== want.length) begin
                $error("length: expected %0d, actual %0d", want.length, length);
                errors++;
            end
            if (removed !== want.removed) begin
                $error("removed_value: expected %0d, actual %0d", want.removed, removed);
                errors++;
            end
        endfunction

        function int pending();
            return wr_idx - rd_idx;
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [KW-1:0]        i_kind;
    logic [PW-1:0]        i_position;
    logic signed [VW-1:0] i_value;
    logic                 o_valid;
    logic                 i_ready;
    logic [1:0]           o_status;
    logic [LW-1:0]        o_length;
    logic signed [VW-1:0] o_removed_value;

    t_list_scoreboard sb;
    bit               calm;

    array_doubly_linked_list_core #(
        .NODE_COUNT(NODES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_length       (o_length),
        .o_removed_value(o_removed_value)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_valid && o_ready) begin
                sb.note_command(i_kind, i_position, i_value);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_status, o_length, o_removed_value);
            end
        end
    end

    // Result side: stall a random number of cycles before taking each transfer.
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_command(input logic [KW-1:0] kind,
                                input logic [PW-1:0] pos,
                                input logic signed [VW-1:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind <= kind;
        i_position <= pos;
        i_value <= val;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic random_command(input int mix);
        int r;
        int grow;
        int cnt;
        int sel;
        int pick;
        logic [KW-1:0] kind;
        logic [PW-1:0] pos;
        if ($urandom_range(0, 59) == 0) begin
            wait_drained();
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = !calm;
        end
        cnt = int'(sb.count);
        case (mix)
            MIX_BALANCED: begin
                grow = (cnt > 40) ? 30 : 55;
            end
            MIX_FILL: begin
                grow = 80;
            end
            default: begin
                grow = 40;
            end
        endcase
        r = $urandom_range(0, 99);
        sel = $urandom_range(0, 2);
        if (r >= 97) begin
            kind = sel[0] ? KIND_UNUSED_A : KIND_UNUSED_B;
        end else if (r < grow) begin
            kind = (sel == 0) ? adll_pkg::KIND_APPEND :
                   (sel == 1) ? adll_pkg::KIND_PREPEND : adll_pkg::KIND_INSERT;
        end else begin
            kind = (sel == 0) ? adll_pkg::KIND_DROP_BACK :
                   (sel == 1) ? adll_pkg::KIND_DROP_FRONT : adll_pkg::KIND_ERASE;
        end
        // Mostly legal positions, with the boundary and the first illegal one
        // picked often, and now and then any 11-bit value.
        pos = PW'($urandom_range(0, 2047));
        pick = $urandom_range(0, 9);
        if (kind == adll_pkg::KIND_INSERT) begin
            if (pick == 1) begin
                pos = PW'(cnt + 1);
            end else if (pick == 2) begin
                pos = PW'(cnt);
            end else if (pick > 2) begin
                pos = PW'($urandom_range(0, cnt));
            end
        end else if (kind == adll_pkg::KIND_ERASE && cnt > 0) begin
            if (pick == 1) begin
                pos = PW'(cnt);
            end else if (pick == 2) begin
                pos = PW'(cnt - 1);
            end else if (pick > 2) begin
                pos = PW'($urandom_range(0, cnt - 1));
            end
        end
        send_command(kind, pos, $urandom());
    endtask

    // Watchdog, several times the slowest legal run.
    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_kind = '0;
        i_position = '0;
        i_value = '0;
        calm = 1'b0;
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Commands on the empty list, then pushes to fill it; erase reports empty before range.
        send_command(adll_pkg::KIND_DROP_BACK, 11'd0, 32'd0);
        send_command(adll_pkg::KIND_DROP_FRONT, 11'h7FF, 32'hFFFF_FFFF);
        send_command(adll_pkg::KIND_ERASE, 11'd0, 32'd0);
        send_command(adll_pkg::KIND_ERASE, 11'h7FF, 32'd0);
        send_command(adll_pkg::KIND_INSERT, 11'd1, 32'h1234_5678);
        send_command(adll_pkg::KIND_INSERT, 11'd0, 32'h8000_0000);
        send_command(adll_pkg::KIND_APPEND, 11'd0, 32'h7FFF_FFFF);
        send_command(adll_pkg::KIND_PREPEND, 11'd0, 32'd0);
        send_command(adll_pkg::KIND_APPEND, 11'd0, 32'hFFFF_FFFF);
        // Insert at the length appends at the back.
        send_command(adll_pkg::KIND_INSERT, 11'd4, 32'h5555_5555);
        send_command(adll_pkg::KIND_INSERT, 11'd2, 32'hAAAA_AAAA);
        send_command(adll_pkg::KIND_INSERT, 11'd7, 32'h0000_0001);
        send_command(adll_pkg::KIND_INSERT, 11'h7FF, 32'h0000_0002);
        send_command(adll_pkg::KIND_ERASE, 11'd6, 32'd0);
        send_command(adll_pkg::KIND_ERASE, 11'h7FF, 32'd0);
        send_command(adll_pkg::KIND_ERASE, 11'd0, 32'd0);
        send_command(adll_pkg::KIND_ERASE, 11'd4, 32'd0);
        send_command(adll_pkg::KIND_ERASE, 11'd1, 32'd0);
        send_command(KIND_UNUSED_A, 11'h555, 32'h0F0F_0F0F);
        send_command(KIND_UNUSED_B, 11'h2AA, 32'hF0F0_F0F0);
        send_command(adll_pkg::KIND_DROP_FRONT, 11'd0, 32'd0);
        send_command(adll_pkg::KIND_DROP_BACK, 11'd0, 32'd0);
        send_command(adll_pkg::KIND_DROP_BACK, 11'd0, 32'd0);
        send_command(adll_pkg::KIND_DROP_FRONT, 11'd0, 32'd0);
        wait_drained();

        repeat (200) random_command(MIX_BALANCED);
        // Grow the list so that the walks get long, then let it shrink again.
        repeat (300) random_command(MIX_FILL);
        repeat (60) random_command(MIX_SHRINK);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
